@@ hdl/bbc_pkg.sv @@
// Package with the shared types and constants of the bracket balance checker.
`default_nettype none

package bbc_pkg;

  localparam int DEFAULT_STACK_DEPTH = 64;

  localparam logic [7:0] CHAR_OPEN_BRACE    = 8'h7B;
  localparam logic [7:0] CHAR_OPEN_PAREN    = 8'h28;
  localparam logic [7:0] CHAR_OPEN_BRACKET  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE_BRACE   = 8'h7D;
  localparam logic [7:0] CHAR_CLOSE_PAREN   = 8'h29;
  localparam logic [7:0] CHAR_CLOSE_BRACKET = 8'h5D;

  typedef logic [1:0] code_t;

  localparam code_t CODE_BRACE   = 2'd0;
  localparam code_t CODE_PAREN   = 2'd1;
  localparam code_t CODE_BRACKET = 2'd2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_string;
  } char_t;

  typedef struct packed {
    logic balanced;
    logic overflow;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/bracket_balance_checker_top.sv @@
// Top level of the bracket balance checker: stack control, memory and result buffer.
//
//   Channel   Direction  Handshake                   Payload
//   char      in         char_valid / char_stall     char_data (char_t)
//   result    out        result_valid / result_stall result_data (result_t)
//
// One byte is taken every cycle unless stalled; the top of stack sits in a register and
// the entry below it is kept read ahead from the stack memory, so a pop never waits on
// a read. A result appears in the cycle after its last byte is accepted when the result
// register is free, and waits in the skid stage while an earlier result is stalled.
// Reset is synchronous and clears the count and flags; the memory is not cleared.
// The char channel stalls only while the result skid stage holds a waiting result.
`default_nettype none

module bracket_balance_checker_top
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    char_valid,
  output logic         char_stall,
  input  wire char_t   char_data,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  logic          accept;
  logic          is_open;
  logic          is_close;
  code_t         char_code;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  code_t         top;
  code_t         top_next;
  logic          failed;
  logic          failed_next;
  logic          overflowed;
  logic          overflowed_next;
  logic          push;
  code_t         below;
  logic [CW-1:0] below_index;
  logic          buf_full;
  logic          res_push;
  result_t       res_data;

  assign accept     = char_valid && !char_stall;
  assign char_stall = buf_full;

  always_comb begin
    is_open   = 1'b0;
    is_close  = 1'b0;
    char_code = CODE_BRACE;
    case (char_data.in_char)
      CHAR_OPEN_BRACE: begin
        is_open   = 1'b1;
        char_code = CODE_BRACE;
      end
      CHAR_OPEN_PAREN: begin
        is_open   = 1'b1;
        char_code = CODE_PAREN;
      end
      CHAR_OPEN_BRACKET: begin
        is_open   = 1'b1;
        char_code = CODE_BRACKET;
      end
      CHAR_CLOSE_BRACE: begin
        is_close  = 1'b1;
        char_code = CODE_BRACE;
      end
      CHAR_CLOSE_PAREN: begin
        is_close  = 1'b1;
        char_code = CODE_PAREN;
      end
      CHAR_CLOSE_BRACKET: begin
        is_close  = 1'b1;
        char_code = CODE_BRACKET;
      end
      default: begin
        is_open  = 1'b0;
        is_close = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_next      = count;
    top_next        = top;
    failed_next     = failed;
    overflowed_next = overflowed;
    push            = 1'b0;
    if (accept && !failed) begin
      if (is_open) begin
        if (count == FULL_COUNT) begin
          failed_next     = 1'b1;
          overflowed_next = 1'b1;
        end else begin
          push       = 1'b1;
          count_next = count + CW'(1);
          top_next   = char_code;
        end
      end else if (is_close) begin
        if (count == '0) begin
          failed_next = 1'b1;
        end else if (top == char_code) begin
          count_next = count - CW'(1);
          top_next   = below;
        end else begin
          failed_next = 1'b1;
        end
      end
    end
    res_push          = accept && char_data.end_of_string;
    res_data.balanced = !failed_next && (count_next == '0);
    res_data.overflow = overflowed_next;
    if (res_push) begin
      count_next      = '0;
      failed_next     = 1'b0;
      overflowed_next = 1'b0;
    end
  end

  assign below_index = count_next - CW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      failed     <= 1'b0;
      overflowed <= 1'b0;
    end else begin
      count      <= count_next;
      failed     <= failed_next;
      overflowed <= overflowed_next;
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
  end

  bbc_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack_mem (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (count[AW-1:0]),
    .wr_data (char_code),
    .rd_addr (below_index[AW-1:0]),
    .rd_data (below)
  );

  bbc_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (res_push),
    .push_data    (res_data),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("Stack count exceeds the stack depth.");

  a_overflow_fails: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> failed)
    else $error("Overflow flag set without the failure flag.");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && char_data.end_of_string) |=> (count == '0) && !failed && !overflowed)
    else $error("State not cleared after the last byte of a string.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && char_data.end_of_string) |=> result_valid)
    else $error("No result offered after the last byte of a string.");
`endif

endmodule

`default_nettype wire

@@ hdl/bbc_stack_mem.sv @@
// Synchronous stack memory with one write port and one registered read port.
`default_nettype none

module bbc_stack_mem
  import bbc_pkg::*;
#(
  parameter int DEPTH = DEFAULT_STACK_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire code_t         wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output code_t              rd_data
);

  code_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/bbc_out_buf.sv @@
// Output register with a skid stage for the result channel.
`default_nettype none

module bbc_out_buf
  import bbc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;
  logic    load_out;

  assign pop      = result_valid && !result_stall;
  assign load_out = !result_valid || pop;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (load_out) begin
      result_valid <= skid_valid || push;
      skid_valid   <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        result_data <= skid_data;
        skid_data   <= push_data;
      end else begin
        result_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ bench/bracket_balance_checker_checker.sv @@
// Checker that predicts and compares every result transaction of the bracket balance checker.
`default_nettype none

module bracket_balance_checker_checker
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    char_valid,
  input  wire logic    char_stall,
  input  wire char_t   char_data,
  input  wire logic    result_valid,
  input  wire logic    result_stall,
  input  wire result_t result_data,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  code_t   nest_codes [STACK_DEPTH];
  int      nest_depth = 0;
  logic    nest_failed = 1'b0;
  logic    nest_overflowed = 1'b0;
  result_t verdict_q [$];
  int      errors = 0;

  task automatic push_code(input code_t k);
    if (nest_depth < STACK_DEPTH) begin
      nest_codes[nest_depth] = k;
      nest_depth++;
    end else begin
      nest_failed = 1'b1;
      nest_overflowed = 1'b1;
    end
  endtask

  task automatic pop_code(input code_t k);
    if (nest_depth == 0) begin
      nest_failed = 1'b1;
    end else if (nest_codes[nest_depth-1] == k) begin
      nest_depth--;
    end else begin
      nest_failed = 1'b1;
    end
  endtask

  task automatic take_char(input char_t c);
    result_t r;
    if (!nest_failed) begin
      case (c.in_char)
        CHAR_OPEN_BRACE:    push_code(CODE_BRACE);
        CHAR_OPEN_PAREN:    push_code(CODE_PAREN);
        CHAR_OPEN_BRACKET:  push_code(CODE_BRACKET);
        CHAR_CLOSE_BRACE:   pop_code(CODE_BRACE);
        CHAR_CLOSE_PAREN:   pop_code(CODE_PAREN);
        CHAR_CLOSE_BRACKET: pop_code(CODE_BRACKET);
        default: ;
      endcase
    end
    if (c.end_of_string) begin
      r.balanced = !nest_failed && (nest_depth == 0);
      r.overflow = nest_overflowed;
      verdict_q.push_back(r);
      nest_depth = 0;
      nest_failed = 1'b0;
      nest_overflowed = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      nest_depth = 0;
      nest_failed = 1'b0;
      nest_overflowed = 1'b0;
      verdict_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result transaction: balanced=%0b overflow=%0b",
                     result_data.balanced, result_data.overflow);
          end
        end else begin
          want = verdict_q.pop_front();
          if (want.balanced !== result_data.balanced ||
              want.overflow !== result_data.overflow) begin
            errors++;
            if (errors <= 10) begin
              $display({"result mismatch: expected balanced=%0b overflow=%0b,",
                        " got balanced=%0b overflow=%0b"},
                       want.balanced, want.overflow,
                       result_data.balanced, result_data.overflow);
            end
          end
        end
      end
      if (char_valid && !char_stall) begin
        take_char(char_data);
      end
    end
    fail_count <= errors;
    pending <= verdict_q.size();
  end

endmodule

`default_nettype wire

@@ bench/bracket_balance_checker_top_tb.sv @@
// Testbench top that drives strings into the bracket balance checker and gives the verdict.
`default_nettype none

module bracket_balance_checker_top_tb
  import bbc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    char_valid = 1'b0;
  logic    char_stall;
  char_t   char_data = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result_data;
  int      fail_count;
  int      pending;

  logic    calm = 1'b0;
  logic    hold_request = 1'b0;
  logic    hold_done = 1'b0;
  int      bytes_sent = 0;

  always #1 clk = ~clk;

  bracket_balance_checker_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  bracket_balance_checker_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] open_char(input code_t k);
    case (k)
      CODE_BRACE: return CHAR_OPEN_BRACE;
      CODE_PAREN: return CHAR_OPEN_PAREN;
      default:    return CHAR_OPEN_BRACKET;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input code_t k);
    case (k)
      CODE_BRACE: return CHAR_CLOSE_BRACE;
      CODE_PAREN: return CHAR_CLOSE_PAREN;
      default:    return CHAR_CLOSE_BRACKET;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      char_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    char_valid <= 1'b1;
    char_data <= '{in_char: c, end_of_string: eos};
    do @(posedge clk); while (char_stall);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_run(input logic [7:0] c, input int n, input logic eos);
    for (int i = 0; i < n; i++) begin
      send_char(c, eos && (i == n - 1));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    char_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_string();
    logic [7:0] text [$];
    code_t      open_stk [$];
    code_t      k;
    int         kind;
    int         r;
    int         target;
    int         n_open;
    int         opened;
    int         pos;
    logic       deep;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 1)) begin
          k = code_t'($urandom_range(0, 2));
          text.push_back($urandom_range(0, 1) ? open_char(k) : close_char(k));
        end else begin
          text.push_back(8'($urandom_range(0, 255)));
        end
      end
    end else begin
      r = $urandom_range(0, 99);
      if (r < 88) target = $urandom_range(1, 6);
      else if (r < 95) target = $urandom_range(7, 64);
      else target = $urandom_range(65, 70);
      deep = (target > 6);
      n_open = deep ? target : target + $urandom_range(0, 4);
      opened = 0;
      while (opened < n_open || open_stk.size() > 0) begin
        if (open_stk.size() < target && opened < n_open &&
            (open_stk.size() == 0 || deep || $urandom_range(0, 1))) begin
          k = code_t'($urandom_range(0, 2));
          open_stk.push_back(k);
          text.push_back(open_char(k));
          opened++;
        end else begin
          k = open_stk.pop_back();
          text.push_back(close_char(k));
        end
        if ($urandom_range(0, 9) == 0) text.push_back(8'($urandom_range(0, 255)));
      end
      if (kind >= 75) begin
        pos = $urandom_range(0, text.size() - 1);
        k = code_t'($urandom_range(0, 2));
        case ($urandom_range(0, 2))
          0:       text[pos] = close_char(k);
          1:       void'(text.pop_back());
          default: text.insert(pos, close_char(k));
        endcase
        if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (int i = 0; i < text.size(); i++) begin
      send_char(text[i], i == text.size() - 1);
    end
  endtask

  initial begin
    wait (!rst);
    forever begin
      int n;
      @(negedge clk);
      if (hold_request && !hold_done) begin
        result_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
        result_stall <= 1'b0;
      end else begin
        n = pick_gap();
        result_stall <= (n != 0);
        if (n > 1) repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("()");
    send_text("{[]}");
    send_text("(]");
    send_text(")");
    send_text("](}{)");
    send_text("((");
    send_text("a{b}c");
    send_run(CHAR_OPEN_BRACKET, 64, 1'b0);
    send_run(CHAR_CLOSE_BRACKET, 64, 1'b1);
    send_run(CHAR_OPEN_PAREN, 66, 1'b1);
    send_text("()");
    drain();

    while (bytes_sent < 900) begin
      calm = ($urandom_range(0, 9) == 0);
      random_string();
    end
    calm = 1'b0;
    drain();

    calm = 1'b1;
    hold_request = 1'b1;
    repeat (40) send_char(8'($urandom_range(0, 255)), 1'b1);
    wait (hold_done);
    hold_request = 1'b0;
    calm = 1'b0;

    while (bytes_sent < 1600) begin
      calm = ($urandom_range(0, 9) == 0);
      random_string();
    end
    calm = 1'b0;
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
